### rtl/ncsv_pkg.sv
// ----------------------------------------------------------------------------
// ncsv_pkg: shared constants and types
// Sizes, widths and the control struct passed between the sequencer and the
// shared squaring unit of the nearest-centroid song vote block.
// ----------------------------------------------------------------------------
package ncsv_pkg;

   // Block dimensions
   localparam int CLUSTERS  = 8;
   localparam int FEATURES  = 39;
   localparam int VOTE_BITS = 12;

   // Port field widths (fixed by the interface)
   localparam int OP_W      = 1;
   localparam int CL_PORT_W = 3;
   localparam int FIDX_W    = 6;
   localparam int VALUE_W   = 16;
   localparam int PREV_W    = 4;
   localparam int WIN_W     = 12;

   // Datapath widths: Q5.12 difference, Q8.24 square, Q16.24 sum
   localparam int DIFF_W    = VALUE_W + 1;
   localparam int SQ_W      = 2 * VALUE_W;
   localparam int SUM_W     = 40;

   // Index and counter widths
   localparam int CIDX_W    = $clog2(CLUSTERS);
   localparam int CNT_W     = $clog2(CLUSTERS + 1);
   localparam int DEPTH     = CLUSTERS * FEATURES;
   localparam int ADDR_W    = $clog2(DEPTH);

   // Operation codes
   localparam logic [OP_W-1:0] OP_LOAD    = 1'b0;
   localparam logic [OP_W-1:0] OP_FEATURE = 1'b1;

   // Control travelling alongside the squaring pipeline
   typedef struct packed {
      logic              vld;
      logic [CIDX_W-1:0] idx;
   } sq_ctl_type;

endpackage

### rtl/ncsv_ram.sv
// ----------------------------------------------------------------------------
// ncsv_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ncsv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 312
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ncsv_sq_unit.sv
// ----------------------------------------------------------------------------
// ncsv_sq_unit: shared difference-and-square unit
// Subtracts a centroid element from the feature element and squares the
// exact Q5.12 difference, registering the Q8.24 result with its cluster tag.
// ----------------------------------------------------------------------------
module ncsv_sq_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ncsv_pkg::sq_ctl_type                   ctl_in,
   input  logic signed [ncsv_pkg::VALUE_W-1:0]    value,
   input  logic signed [ncsv_pkg::VALUE_W-1:0]    centroid,
   output ncsv_pkg::sq_ctl_type                   ctl_out,
   output logic        [ncsv_pkg::SQ_W-1:0]       sq
);

   logic signed [ncsv_pkg::DIFF_W-1:0]   diff;
   logic signed [2*ncsv_pkg::DIFF_W-1:0] prod;
   logic        [ncsv_pkg::SQ_W-1:0]     sq_ff;
   ncsv_pkg::sq_ctl_type                 ctl_ff;

   // Exact difference, then square (always non-negative, fits SQ_W bits)
   always_comb begin
      diff = {value[ncsv_pkg::VALUE_W-1], value}
           - {centroid[ncsv_pkg::VALUE_W-1], centroid};
      prod = diff * diff;
   end

   always_ff @(posedge clock) begin
      sq_ff <= prod[ncsv_pkg::SQ_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   assign ctl_out = ctl_ff;
   assign sq      = sq_ff;

endmodule

### rtl/nearest_centroid_song_vote.sv
// ----------------------------------------------------------------------------
// nearest_centroid_song_vote: k-means nearest-centroid voting over a song
// Load transactions fill a centroid table; feature transactions accumulate
// squared distances, cast a segment vote and report the song's winner.
// Usage:
//   req_* carries one transaction and is taken only while the sequencer is
//   idle. A load writes one centroid element and can be taken every cycle.
//   A feature transaction reads one centroid element per cluster through the
//   single RAM read port and squarer and holds the block until the last
//   squared term lands in its sum; an out-of-range feature index skips this
//   phase. A segment end adds a minimum scan over the clusters and a vote
//   step; a song end adds a maximum scan over the clusters and a step that
//   loads the result, which raises rsp_valid once the previous result has
//   been taken. rsp_* is a held output register: new transactions are taken
//   while a result waits, but the next result waits in the sequencer until
//   the receiver has taken the previous one. Reset clears the sequencer,
//   sums, votes and result valid; the centroid table is undefined until
//   loaded.
// ----------------------------------------------------------------------------
module nearest_centroid_song_vote (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [ncsv_pkg::OP_W-1:0]              req_operation,
   input  logic [ncsv_pkg::CL_PORT_W-1:0]         req_cluster_index,
   input  logic [ncsv_pkg::FIDX_W-1:0]            req_feature_index,
   input  logic signed [ncsv_pkg::VALUE_W-1:0]    req_feature_value,
   input  logic                                   req_segment_end,
   input  logic                                   req_song_end,
   input  logic [ncsv_pkg::PREV_W-1:0]            req_previous_cluster,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [ncsv_pkg::CL_PORT_W-1:0]         rsp_assigned_cluster,
   output logic                                   rsp_changed,
   output logic [ncsv_pkg::WIN_W-1:0]             rsp_winning_votes
);

   // Sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ACC  = 3'd1;
   localparam logic [2:0] ST_MIN  = 3'd2;
   localparam logic [2:0] ST_VOTE = 3'd3;
   localparam logic [2:0] ST_MAX  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   localparam logic [ncsv_pkg::CIDX_W-1:0] LAST_CL =
      ncsv_pkg::CIDX_W'(ncsv_pkg::CLUSTERS - 1);

   logic [2:0]                          state_ff, state_in;
   logic [ncsv_pkg::CNT_W-1:0]          cnt_ff, cnt_in;
   logic [ncsv_pkg::ADDR_W-1:0]         addr_ff, addr_in;
   logic signed [ncsv_pkg::VALUE_W-1:0] value_ff, value_in;
   logic                                seg_ff, seg_in;
   logic                                song_ff, song_in;
   logic [ncsv_pkg::PREV_W-1:0]         prev_ff, prev_in;
   logic [ncsv_pkg::CIDX_W-1:0]         best_idx_ff, best_idx_in;
   logic [ncsv_pkg::SUM_W-1:0]          best_sum_ff, best_sum_in;
   logic [ncsv_pkg::VOTE_BITS-1:0]      best_vote_ff, best_vote_in;
   logic [ncsv_pkg::SUM_W-1:0]          sums_ff  [ncsv_pkg::CLUSTERS];
   logic [ncsv_pkg::SUM_W-1:0]          sums_in  [ncsv_pkg::CLUSTERS];
   logic [ncsv_pkg::VOTE_BITS-1:0]      votes_ff [ncsv_pkg::CLUSTERS];
   logic [ncsv_pkg::VOTE_BITS-1:0]      votes_in [ncsv_pkg::CLUSTERS];
   ncsv_pkg::sq_ctl_type                rd_ctl_ff, rd_ctl_in;
   ncsv_pkg::sq_ctl_type                sq_ctl;
   logic [ncsv_pkg::SQ_W-1:0]           sq;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [ncsv_pkg::CL_PORT_W-1:0]      rsp_cl_ff, rsp_cl_in;
   logic                                rsp_chg_ff, rsp_chg_in;
   logic [ncsv_pkg::WIN_W-1:0]          rsp_win_ff, rsp_win_in;

   logic                                req_accept;
   logic                                load_en;
   logic [ncsv_pkg::ADDR_W-1:0]         load_addr;
   logic                                rd_en;
   logic [ncsv_pkg::VALUE_W-1:0]        rd_data;
   logic [ncsv_pkg::CIDX_W-1:0]         scan_idx;
   logic [ncsv_pkg::SUM_W:0]            acc_sum;

   assign req_accept = req_valid && req_ready;
   assign req_ready  = (state_ff == ST_IDLE);
   assign scan_idx   = cnt_ff[ncsv_pkg::CIDX_W-1:0];

   // Centroid load address and range check
   always_comb begin
      load_addr = ncsv_pkg::ADDR_W'(req_cluster_index)
                * ncsv_pkg::ADDR_W'(ncsv_pkg::FEATURES)
                + ncsv_pkg::ADDR_W'(req_feature_index);
      load_en   = req_accept && (req_operation == ncsv_pkg::OP_LOAD)
               && (int'(req_cluster_index) < ncsv_pkg::CLUSTERS)
               && (int'(req_feature_index) < ncsv_pkg::FEATURES);
   end

   // Centroid table read issue: one cluster per cycle
   assign rd_en = (state_ff == ST_ACC) && (int'(cnt_ff) < ncsv_pkg::CLUSTERS);

   ncsv_ram #(
      .WIDTH (ncsv_pkg::VALUE_W),
      .DEPTH (ncsv_pkg::DEPTH)
   ) u_centroid_ram (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (load_addr),
      .wr_data (req_feature_value),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   ncsv_sq_unit u_sq_unit (
      .clock    (clock),
      .reset    (reset),
      .ctl_in   (rd_ctl_ff),
      .value    (value_ff),
      .centroid ($signed(rd_data)),
      .ctl_out  (sq_ctl),
      .sq       (sq)
   );

   // Saturating accumulate of the squared term into the tagged cluster's sum
   assign acc_sum = {1'b0, sums_ff[sq_ctl.idx]} + (ncsv_pkg::SUM_W + 1)'(sq);

   // Sequencer and datapath next-state
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      addr_in      = addr_ff;
      value_in     = value_ff;
      seg_in       = seg_ff;
      song_in      = song_ff;
      prev_in      = prev_ff;
      best_idx_in  = best_idx_ff;
      best_sum_in  = best_sum_ff;
      best_vote_in = best_vote_ff;
      sums_in      = sums_ff;
      votes_in     = votes_ff;
      rd_ctl_in    = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_cl_in    = rsp_cl_ff;
      rsp_chg_in   = rsp_chg_ff;
      rsp_win_in   = rsp_win_ff;

      // squared term lands in its sum
      if (sq_ctl.vld) begin
         sums_in[sq_ctl.idx] = acc_sum[ncsv_pkg::SUM_W] ? '1
                                                        : acc_sum[ncsv_pkg::SUM_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_operation == ncsv_pkg::OP_FEATURE)) begin
               addr_in  = ncsv_pkg::ADDR_W'(req_feature_index);
               value_in = req_feature_value;
               seg_in   = req_segment_end || req_song_end;
               song_in  = req_song_end;
               prev_in  = req_previous_cluster;
               cnt_in   = '0;
               if (int'(req_feature_index) < ncsv_pkg::FEATURES) begin
                  state_in = ST_ACC;
               end else if (req_segment_end || req_song_end) begin
                  state_in = ST_MIN;
               end
            end
         end
         ST_ACC: begin
            if (rd_en) begin
               rd_ctl_in.vld = 1'b1;
               rd_ctl_in.idx = scan_idx;
               addr_in       = addr_ff + ncsv_pkg::ADDR_W'(ncsv_pkg::FEATURES);
               cnt_in        = cnt_ff + 1'b1;
            end
            if (sq_ctl.vld && (sq_ctl.idx == LAST_CL)) begin
               cnt_in   = '0;
               state_in = seg_ff ? ST_MIN : ST_IDLE;
            end
         end
         ST_MIN: begin
            // first strict minimum of the distance sums
            if ((cnt_ff == '0) || (sums_ff[scan_idx] < best_sum_ff)) begin
               best_idx_in = scan_idx;
               best_sum_in = sums_ff[scan_idx];
            end
            cnt_in = cnt_ff + 1'b1;
            if (scan_idx == LAST_CL) begin
               cnt_in   = '0;
               state_in = ST_VOTE;
            end
         end
         ST_VOTE: begin
            if (votes_ff[best_idx_ff] != '1) begin
               votes_in[best_idx_ff] = votes_ff[best_idx_ff] + 1'b1;
            end
            for (int c = 0; c < ncsv_pkg::CLUSTERS; c++) begin
               sums_in[c] = '0;
            end
            state_in = song_ff ? ST_MAX : ST_IDLE;
         end
         ST_MAX: begin
            // first maximum of the vote counts
            if ((cnt_ff == '0) || (votes_ff[scan_idx] > best_vote_ff)) begin
               best_idx_in  = scan_idx;
               best_vote_in = votes_ff[scan_idx];
            end
            cnt_in = cnt_ff + 1'b1;
            if (scan_idx == LAST_CL) begin
               cnt_in   = '0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_cl_in    = ncsv_pkg::CL_PORT_W'(best_idx_ff);
               rsp_chg_in   = ncsv_pkg::PREV_W'(best_idx_ff) != prev_ff;
               rsp_win_in   = ncsv_pkg::WIN_W'(best_vote_ff);
               for (int c = 0; c < ncsv_pkg::CLUSTERS; c++) begin
                  votes_in[c] = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers and reset-valued state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rd_ctl_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < ncsv_pkg::CLUSTERS; c++) begin
            sums_ff[c]  <= '0;
            votes_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_ctl_ff    <= rd_ctl_in;
         rsp_valid_ff <= rsp_valid_in;
         sums_ff      <= sums_in;
         votes_ff     <= votes_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      value_ff     <= value_in;
      seg_ff       <= seg_in;
      song_ff      <= song_in;
      prev_ff      <= prev_in;
      best_idx_ff  <= best_idx_in;
      best_sum_ff  <= best_sum_in;
      best_vote_ff <= best_vote_in;
      rsp_cl_ff    <= rsp_cl_in;
      rsp_chg_ff   <= rsp_chg_in;
      rsp_win_ff   <= rsp_win_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_assigned_cluster = rsp_cl_ff;
   assign rsp_changed          = rsp_chg_ff;
   assign rsp_winning_votes    = rsp_win_ff;

   // Assertions
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result appeared outside the output state");

   a_sq_in_acc: assert property (@(posedge clock) disable iff (reset)
      sq_ctl.vld |-> (state_ff == ST_ACC))
      else $error("squared term arrived outside accumulation");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC) |-> (int'(cnt_ff) <= ncsv_pkg::CLUSTERS))
      else $error("read counter ran past the last cluster");

   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      load_en |-> (state_ff == ST_IDLE))
      else $error("centroid write while sequencer busy");

endmodule
